// ===== rtl/core/sse_pkg.sv =====
// Package with the shared types and codes of the sorted set successor engine.
package sse_pkg;

   // Field widths at the ports.
   localparam int PORT_KEY_W   = 32;
   localparam int ACTION_W     = 2;
   localparam int STATUS_W     = 2;

   // Default sizes of the store.
   localparam int DEF_CAPACITY  = 64;
   localparam int DEF_KEY_WIDTH = 32;

   // Action codes carried by a request transaction.
   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_ERASE  = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   // Status codes carried by a response transaction.
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FOUND = 2'd1,
      ST_NONE  = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_CMP  = 2'd1,
      S_UPD  = 2'd2
   } state_type;

   // Control broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic cmp_en;
      logic ins_en;
      logic ers_en;
   } ctl_type;

endpackage

// ===== rtl/core/sse_cell.sv =====
// One cell of the sorted key chain: holds a key and its compare flags.
module sse_cell #(
   parameter int KEY_WIDTH = sse_pkg::DEF_KEY_WIDTH
) (
   input  logic                 clock,
   input  sse_pkg::ctl_type     ctl,
   input  logic [KEY_WIDTH-1:0] search_key,
   input  logic                 occ,
   input  logic [KEY_WIDTH-1:0] left_key,
   input  logic                 left_atpos,
   input  logic [KEY_WIDTH-1:0] right_key,
   output logic [KEY_WIDTH-1:0] key_out,
   output logic                 atpos_out,
   output logic                 eq_out,
   output logic                 hit_out,
   output logic [KEY_WIDTH-1:0] sel_key
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic                 geocc_ff;
   logic                 geocc_in;
   logic                 eq_ff;
   logic                 eq_in;
   logic                 hit;

   // Compare flags are captured in the compare cycle.
   always_comb begin
      geocc_in = geocc_ff;
      eq_in    = eq_ff;
      if (ctl.cmp_en) begin
         geocc_in = occ && (key_ff >= search_key);
         eq_in    = occ && (key_ff == search_key);
      end
   end

   // This cell is at or past the insertion point; the first such cell is the hit.
   assign atpos_out = geocc_ff || !occ;
   assign hit       = atpos_out && !left_atpos;

   // Insert shifts keys right from the hit; erase pulls keys left from the hit.
   always_comb begin
      key_in = key_ff;
      if (ctl.ins_en) begin
         if (hit) begin
            key_in = search_key;
         end else if (atpos_out) begin
            key_in = left_key;
         end
      end else if (ctl.ers_en) begin
         if (atpos_out) begin
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      geocc_ff <= geocc_in;
      eq_ff    <= eq_in;
   end

   assign key_out = key_ff;
   assign eq_out  = eq_ff;
   assign hit_out = hit && geocc_ff;
   assign sel_key = (hit && geocc_ff) ? key_ff : '0;

endmodule

// ===== rtl/core/sorted_set_successor_engine.sv =====
// Top level of the sorted set successor engine: sequencer, count and cell chain.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_action, req_key
//   rsp       out        rsp_valid/rsp_stall  rsp_status, rsp_found_key
//
// Each transaction passes in turn through the accept step, the compare step in
// every cell, and then the update step; one item is worked on at a time. A
// stalled response holds the update step until the output register is free.
// Reset clears the count, so the store reads empty at once; the stored keys
// themselves need no clearing.
module sorted_set_successor_engine #(
   parameter int CAPACITY  = sse_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = sse_pkg::DEF_KEY_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sse_pkg::ACTION_W-1:0]    req_action,
   input  logic [sse_pkg::PORT_KEY_W-1:0]  req_key,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sse_pkg::STATUS_W-1:0]    rsp_status,
   output logic [sse_pkg::PORT_KEY_W-1:0]  rsp_found_key
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   sse_pkg::state_type          state_ff;
   sse_pkg::state_type          state_in;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic [sse_pkg::ACTION_W-1:0] act_ff;
   logic [KEY_WIDTH-1:0]        k_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [sse_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [sse_pkg::STATUS_W-1:0] rsp_status_in;
   logic [sse_pkg::PORT_KEY_W-1:0] rsp_key_ff;
   logic [sse_pkg::PORT_KEY_W-1:0] rsp_key_in;

   logic                        accept;
   logic                        slot_free;
   logic                        upd_go;
   logic                        present;
   logic                        full;
   logic                        any_found;
   logic [KEY_WIDTH-1:0]        found_or;
   sse_pkg::ctl_type            ctl;

   logic [KEY_WIDTH-1:0]        key_vec   [CAPACITY];
   logic [KEY_WIDTH-1:0]        sel_vec   [CAPACITY];
   logic [CAPACITY-1:0]         atpos_vec;
   logic [CAPACITY-1:0]         eq_vec;
   logic [CAPACITY-1:0]         hit_vec;
   logic [CAPACITY-1:0]         occ_vec;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sse_pkg::S_IDLE: if (req_valid) state_in = sse_pkg::S_CMP;
         sse_pkg::S_CMP:  state_in = sse_pkg::S_UPD;
         sse_pkg::S_UPD:  if (slot_free) state_in = sse_pkg::S_IDLE;
         default:         state_in = sse_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs, including the shift enables broadcast to the chain.
   always_comb begin
      req_stall  = 1'b1;
      ctl.cmp_en = 1'b0;
      upd_go     = 1'b0;
      unique case (state_ff)
         sse_pkg::S_IDLE: req_stall  = 1'b0;
         sse_pkg::S_CMP:  ctl.cmp_en = 1'b1;
         sse_pkg::S_UPD:  upd_go     = slot_free;
         default:         req_stall  = 1'b1;
      endcase
      ctl.ins_en = upd_go && (act_ff == sse_pkg::ACT_INSERT) && !present && !full;
      ctl.ers_en = upd_go && (act_ff == sse_pkg::ACT_ERASE) && present;
   end

   // Decisions taken from the registered compare flags.
   assign present   = |eq_vec;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign any_found = |hit_vec;

   // Occupancy of each cell follows from the count.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_occ
      assign occ_vec[i] = (CNT_W'(i) < count_ff);
   end

   // The chain of cells.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_key;
      logic                 left_atpos;
      logic [KEY_WIDTH-1:0] right_key;
      if (i == 0) begin : g_first
         assign left_key   = k_ff;
         assign left_atpos = 1'b0;
      end else begin : g_mid
         assign left_key   = key_vec[i-1];
         assign left_atpos = atpos_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_key = key_vec[i];
      end else begin : g_inner
         assign right_key = key_vec[i+1];
      end
      sse_cell #(
         .KEY_WIDTH(KEY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .search_key (k_ff),
         .occ        (occ_vec[i]),
         .left_key   (left_key),
         .left_atpos (left_atpos),
         .right_key  (right_key),
         .key_out    (key_vec[i]),
         .atpos_out  (atpos_vec[i]),
         .eq_out     (eq_vec[i]),
         .hit_out    (hit_vec[i]),
         .sel_key    (sel_vec[i])
      );
   end

   // At most one cell offers its key; OR them together.
   always_comb begin
      found_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         found_or = found_or | sel_vec[i];
      end
   end

   // Count update.
   always_comb begin
      count_in = count_ff;
      if (ctl.ins_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.ers_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Response transaction contents.
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      if (upd_go) begin
         rsp_key_in = '0;
         case (act_ff)
            sse_pkg::ACT_INSERT: begin
               rsp_status_in = (!present && full) ? sse_pkg::ST_FULL : sse_pkg::ST_DONE;
            end
            sse_pkg::ACT_ERASE: begin
               rsp_status_in = sse_pkg::ST_DONE;
            end
            default: begin
               rsp_status_in = any_found ? sse_pkg::ST_FOUND : sse_pkg::ST_NONE;
               rsp_key_in    = sse_pkg::PORT_KEY_W'(found_or);
            end
         endcase
      end
   end

   assign rsp_valid_in = upd_go || (rsp_valid_ff && rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sse_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         k_ff   <= KEY_WIDTH'(req_key);
      end
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found_key = rsp_key_ff;

`ifndef SYNTH
   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // Keys are distinct, so at most one cell matches.
   a_eq_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sse_pkg::S_UPD) |-> $onehot0(eq_vec))
      else $error("more than one cell matches the key");

   // Only one cell can be the successor.
   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one successor cell");

   // Insert and erase never shift in the same cycle.
   a_shift_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctl.ins_en && ctl.ers_en))
      else $error("insert and erase shift together");

   // An accepted transaction goes through the compare step and then reaches the update step.
   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 (state_ff == sse_pkg::S_UPD))
      else $error("sequencer skipped the compare step");
`endif

endmodule
